// ===== src/wrsi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wrsi_pkg;

    localparam int PRICE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int AVG_W       = 56;
    localparam int PERIOD_W    = 8;
    localparam int RSI_W       = 14;
    localparam int NUM_W       = AVG_W + RSI_W;
    localparam int DEN_W       = AVG_W + 1;
    localparam int CNT_W       = $clog2(AVG_W + 1);

    localparam logic [RSI_W-1:0]    RSI_FULL     = RSI_W'(10000);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] iters;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== src/wrsi_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wrsi_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wrsi_pkg::t_div_req               i_req,
    input  wire  [wrsi_pkg::DEN_W-1:0]       i_rem_init,
    input  wire  [wrsi_pkg::AVG_W-1:0]       i_dvd,
    input  wire  [wrsi_pkg::DEN_W-1:0]       i_divisor,
    output wrsi_pkg::t_div_rsp               o_rsp,
    output logic [wrsi_pkg::AVG_W-1:0]       o_quo
);

    logic                          r_busy;
    logic                          r_done;
    logic [wrsi_pkg::CNT_W-1:0]    r_cnt;
    logic [wrsi_pkg::DEN_W-1:0]    r_rem;
    logic [wrsi_pkg::AVG_W-1:0]    r_dvd;
    logic [wrsi_pkg::DEN_W-1:0]    r_div;
    logic [wrsi_pkg::AVG_W-1:0]    r_quo;

    logic [wrsi_pkg::DEN_W:0]      w_rem2;
    logic [wrsi_pkg::DEN_W:0]      w_diff;
    logic                          w_ge;

    // One restoring step per cycle: shift in the next dividend bit and subtract if it fits.
    assign w_rem2 = {r_rem, r_dvd[wrsi_pkg::AVG_W-1]};
    assign w_diff = w_rem2 - {1'b0, r_div};
    assign w_ge   = (w_rem2 >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == wrsi_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_rem_init;
            r_dvd <= i_dvd;
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[wrsi_pkg::DEN_W-1:0] : w_rem2[wrsi_pkg::DEN_W-1:0];
            r_dvd <= {r_dvd[wrsi_pkg::AVG_W-2:0], 1'b0};
            r_quo <= {r_quo[wrsi_pkg::AVG_W-2:0], w_ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quo      = r_quo;

endmodule

`default_nettype wire

// ===== src/wilder_rsi_stream.sv =====
// Channel  | valid        | stall        | payload
// input    | i_in_valid   | o_in_stall   | i_close_price, i_restart
// output   | o_out_valid  | i_out_stall  | o_rsi_hundredths, o_loss_was_zero
// config   | i_cfg_wr_en  | none         | i_cfg_wr_data (period)
//
// A restart or warm-up item only updates the series state; a result may wait for the
// output register. The seeding item divides both sums by the period; each smoothed item
// scales both averages by the period less one, adds the new change and divides by it.
// Divisions use the shared restoring divider, one quotient bit per cycle: two 56-bit
// divisions by the period and, unless the average loss is zero, one 14-bit ratio division.
// Reset is synchronous and clears all series state; the period returns to 14.
// The next item is taken while a finished result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module wilder_rsi_stream (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [31:0]                      i_close_price,
    input  wire                              i_restart,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [wrsi_pkg::RSI_W-1:0]       o_rsi_hundredths,
    output logic                             o_loss_was_zero,
    input  wire                              i_cfg_wr_en,
    input  wire  [wrsi_pkg::PERIOD_W-1:0]    i_cfg_wr_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ACC    = 4'd1;
    localparam logic [3:0] ST_MUL_G  = 4'd2;
    localparam logic [3:0] ST_MUL_L  = 4'd3;
    localparam logic [3:0] ST_DIV_G  = 4'd4;
    localparam logic [3:0] ST_WAIT_G = 4'd5;
    localparam logic [3:0] ST_DIV_L  = 4'd6;
    localparam logic [3:0] ST_WAIT_L = 4'd7;
    localparam logic [3:0] ST_RATIO  = 4'd8;
    localparam logic [3:0] ST_RWAIT  = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;

    logic [3:0]                          r_state;
    logic [wrsi_pkg::PERIOD_W-1:0]       r_period;
    logic [wrsi_pkg::PERIOD_W-1:0]       r_n;
    logic [wrsi_pkg::PRICE_WIDTH-1:0]    r_price;
    logic                                r_restart;
    logic [wrsi_pkg::PRICE_WIDTH-1:0]    r_prev;
    logic                                r_have_prev;
    logic [wrsi_pkg::PERIOD_W-1:0]       r_count;
    logic                                r_seeded;
    logic [wrsi_pkg::AVG_W-1:0]          r_avg_g;
    logic [wrsi_pkg::AVG_W-1:0]          r_avg_l;
    logic [wrsi_pkg::AVG_W-1:0]          r_x_g;
    logic [wrsi_pkg::AVG_W-1:0]          r_x_l;
    logic                                r_out_valid;
    logic [wrsi_pkg::RSI_W-1:0]          r_rsi;
    logic                                r_lz;

    logic                                w_in_fire;
    logic                                w_emit;
    logic [wrsi_pkg::PERIOD_W-1:0]       w_count1;
    logic [wrsi_pkg::PRICE_WIDTH-1:0]    w_up;
    logic [wrsi_pkg::PRICE_WIDTH-1:0]    w_down;
    logic [wrsi_pkg::AVG_W-1:0]          w_gain;
    logic [wrsi_pkg::AVG_W-1:0]          w_loss;
    logic [wrsi_pkg::AVG_W-1:0]          w_mul_a;
    logic [wrsi_pkg::RSI_W-1:0]          w_mul_b;
    logic [wrsi_pkg::NUM_W-1:0]          w_prod;
    logic [wrsi_pkg::AVG_W-1:0]          w_smooth;
    logic [wrsi_pkg::DEN_W-1:0]          w_den;

    wrsi_pkg::t_div_req                  w_req;
    wrsi_pkg::t_div_rsp                  w_rsp;
    logic [wrsi_pkg::DEN_W-1:0]          w_rem_init;
    logic [wrsi_pkg::AVG_W-1:0]          w_dvd;
    logic [wrsi_pkg::DEN_W-1:0]          w_divisor;
    logic [wrsi_pkg::AVG_W-1:0]          w_quo;

    assign w_in_fire = i_in_valid && !o_in_stall;
    assign w_emit    = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_count1  = r_count + 1'b1;

    assign w_up   = r_price - r_prev;
    assign w_down = r_prev - r_price;
    assign w_gain = (r_price > r_prev)
                  ? (wrsi_pkg::AVG_W'(w_up) << wrsi_pkg::FRAC_BITS) : '0;
    assign w_loss = (r_price > r_prev)
                  ? '0 : (wrsi_pkg::AVG_W'(w_down) << wrsi_pkg::FRAC_BITS);

    // The single multiplier serves the smoothing step and the ratio numerator.
    assign w_mul_a  = (r_state == ST_MUL_L) ? r_avg_l : r_avg_g;
    assign w_mul_b  = (r_state == ST_RATIO) ? wrsi_pkg::RSI_FULL
                                            : wrsi_pkg::RSI_W'(r_n - 1'b1);
    assign w_prod   = {{wrsi_pkg::RSI_W{1'b0}}, w_mul_a}
                    * {{wrsi_pkg::AVG_W{1'b0}}, w_mul_b};
    assign w_smooth = w_prod[wrsi_pkg::AVG_W-1:0]
                    + ((r_state == ST_MUL_L) ? r_x_l : r_x_g);
    assign w_den    = {1'b0, r_avg_g} + {1'b0, r_avg_l};

    always_comb begin
        w_req.start = 1'b0;
        w_req.iters = wrsi_pkg::CNT_W'(wrsi_pkg::AVG_W);
        w_rem_init  = '0;
        w_dvd       = r_avg_g;
        w_divisor   = wrsi_pkg::DEN_W'(r_n);
        case (r_state)
            ST_DIV_G: begin
                w_req.start = 1'b1;
            end
            ST_DIV_L: begin
                w_req.start = 1'b1;
                w_dvd       = r_avg_l;
            end
            ST_RATIO: begin
                // The quotient is below 2^14, so the top of the numerator seeds the remainder.
                w_req.start = (r_avg_l != '0);
                w_req.iters = wrsi_pkg::CNT_W'(wrsi_pkg::RSI_W);
                w_rem_init  = wrsi_pkg::DEN_W'(w_prod[wrsi_pkg::NUM_W-1:wrsi_pkg::RSI_W]);
                w_dvd       = {w_prod[wrsi_pkg::RSI_W-1:0],
                               {(wrsi_pkg::AVG_W-wrsi_pkg::RSI_W){1'b0}}};
                w_divisor   = w_den;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    wrsi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_rem_init (w_rem_init),
        .i_dvd      (w_dvd),
        .i_divisor  (w_divisor),
        .o_rsp      (w_rsp),
        .o_quo      (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_period    <= wrsi_pkg::PERIOD_RESET;
            r_n         <= wrsi_pkg::PERIOD_RESET;
            r_price     <= '0;
            r_restart   <= 1'b0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_count     <= '0;
            r_seeded    <= 1'b0;
            r_avg_g     <= '0;
            r_avg_l     <= '0;
            r_x_g       <= '0;
            r_x_l       <= '0;
            r_out_valid <= 1'b0;
            r_rsi       <= '0;
            r_lz        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        r_price   <= wrsi_pkg::PRICE_WIDTH'(i_close_price);
                        r_restart <= i_restart;
                        r_n       <= (r_period == '0) ? wrsi_pkg::PERIOD_W'(1) : r_period;
                        r_state   <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    r_prev <= r_price;
                    if (r_restart || !r_have_prev) begin
                        r_have_prev <= 1'b1;
                        r_count     <= '0;
                        r_seeded    <= 1'b0;
                        r_avg_g     <= '0;
                        r_avg_l     <= '0;
                        r_state     <= ST_IDLE;
                    end else if (!r_seeded) begin
                        r_avg_g <= r_avg_g + w_gain;
                        r_avg_l <= r_avg_l + w_loss;
                        r_count <= w_count1;
                        r_state <= (w_count1 < r_n) ? ST_IDLE : ST_DIV_G;
                    end else begin
                        r_x_g   <= w_gain;
                        r_x_l   <= w_loss;
                        r_state <= ST_MUL_G;
                    end
                end
                ST_MUL_G: begin
                    r_avg_g <= w_smooth;
                    r_state <= ST_MUL_L;
                end
                ST_MUL_L: begin
                    r_avg_l <= w_smooth;
                    r_state <= ST_DIV_G;
                end
                ST_DIV_G: begin
                    r_state <= ST_WAIT_G;
                end
                ST_WAIT_G: begin
                    if (w_rsp.done) begin
                        r_avg_g <= w_quo;
                        r_state <= ST_DIV_L;
                    end
                end
                ST_DIV_L: begin
                    r_state <= ST_WAIT_L;
                end
                ST_WAIT_L: begin
                    if (w_rsp.done) begin
                        r_avg_l  <= w_quo;
                        r_seeded <= 1'b1;
                        r_state  <= ST_RATIO;
                    end
                end
                ST_RATIO: begin
                    if (r_avg_l == '0) begin
                        r_rsi   <= wrsi_pkg::RSI_FULL;
                        r_lz    <= 1'b1;
                        r_state <= ST_EMIT;
                    end else begin
                        r_state <= ST_RWAIT;
                    end
                end
                ST_RWAIT: begin
                    if (w_rsp.done) begin
                        r_rsi   <= w_quo[wrsi_pkg::RSI_W-1:0];
                        r_lz    <= 1'b0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        o_rsi_hundredths <= r_rsi;
                        o_loss_was_zero  <= r_lz;
                        r_state          <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== src/wrsi_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wrsi_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_in_valid,
    input wire                              o_in_stall,
    input wire                              o_out_valid,
    input wire                              i_out_stall,
    input wire [wrsi_pkg::RSI_W-1:0]        o_rsi_hundredths,
    input wire                              o_loss_was_zero
);

    // A result item that is held back stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block ready right after accepting an item");

    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rsi_hundredths <= wrsi_pkg::RSI_FULL))
        else $error("index above full scale");

    a_zero_loss_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_loss_was_zero |-> (o_rsi_hundredths == wrsi_pkg::RSI_FULL))
        else $error("zero average loss without full-scale index");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("channels not idle after reset");

endmodule

bind wilder_rsi_stream wrsi_checker u_wrsi_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_rsi_hundredths (o_rsi_hundredths),
    .o_loss_was_zero  (o_loss_was_zero)
);

`default_nettype wire

// ===== dv/wilder_rsi_stream_checker.sv =====
`timescale 1ns / 1ps

module wilder_rsi_stream_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  wire                              i_in_stall,
    input  wire  [31:0]                      i_close_price,
    input  wire                              i_restart,
    input  wire                              i_out_valid,
    input  wire                              i_out_stall,
    input  wire  [wrsi_pkg::RSI_W-1:0]       i_rsi_hundredths,
    input  wire                              i_loss_was_zero,
    input  wire                              i_cfg_wr_en,
    input  wire  [wrsi_pkg::PERIOD_W-1:0]    i_cfg_wr_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    typedef struct packed {
        logic [wrsi_pkg::RSI_W-1:0] rsi;
        logic                       loss_zero;
    } t_rsi_value;

    t_rsi_value                    rsi_due[$];
    int                            mismatches = 0;

    logic [wrsi_pkg::PERIOD_W-1:0] smoothing_len;
    logic [31:0]                   last_close;
    logic                          have_close;
    logic [7:0]                    changes_seen;
    logic                          averages_seeded;
    logic [wrsi_pkg::AVG_W-1:0]    gain_avg;
    logic [wrsi_pkg::AVG_W-1:0]    loss_avg;

    task automatic advance_series(input logic [31:0] price, input logic fresh);
        logic [63:0]  n;
        logic [63:0]  up;
        logic [63:0]  down;
        logic [63:0]  g_next;
        logic [63:0]  l_next;
        logic [127:0] ratio;
        t_rsi_value   value;

        n = (smoothing_len == 0) ? 64'd1 : 64'(smoothing_len);
        if (fresh || !have_close) begin
            last_close      = price;
            have_close      = 1'b1;
            changes_seen    = '0;
            averages_seeded = 1'b0;
            gain_avg        = '0;
            loss_avg        = '0;
            return;
        end

        up   = '0;
        down = '0;
        if (price > last_close) begin
            up = 64'(price - last_close) << wrsi_pkg::FRAC_BITS;
        end else begin
            down = 64'(last_close - price) << wrsi_pkg::FRAC_BITS;
        end
        last_close = price;

        if (!averages_seeded) begin
            gain_avg     = gain_avg + up[wrsi_pkg::AVG_W-1:0];
            loss_avg     = loss_avg + down[wrsi_pkg::AVG_W-1:0];
            changes_seen = changes_seen + 8'd1;
            if (64'(changes_seen) < n) begin
                return;
            end
            gain_avg        = wrsi_pkg::AVG_W'(64'(gain_avg) / n);
            loss_avg        = wrsi_pkg::AVG_W'(64'(loss_avg) / n);
            averages_seeded = 1'b1;
        end else begin
            g_next   = 64'(gain_avg) * (n - 64'd1) + up;
            l_next   = 64'(loss_avg) * (n - 64'd1) + down;
            gain_avg = wrsi_pkg::AVG_W'(64'(g_next[wrsi_pkg::AVG_W-1:0]) / n);
            loss_avg = wrsi_pkg::AVG_W'(64'(l_next[wrsi_pkg::AVG_W-1:0]) / n);
        end

        if (loss_avg == 0) begin
            value.rsi       = wrsi_pkg::RSI_FULL;
            value.loss_zero = 1'b1;
        end else begin
            ratio = (128'(gain_avg) * 128'd10000) / (128'(gain_avg) + 128'(loss_avg));
            value.rsi       = ratio[wrsi_pkg::RSI_W-1:0];
            value.loss_zero = 1'b0;
        end
        rsi_due.push_back(value);
    endtask

    always @(posedge i_clk) begin
        t_rsi_value want;

        if (!i_rst_n) begin
            smoothing_len   = wrsi_pkg::PERIOD_RESET;
            last_close      = '0;
            have_close      = 1'b0;
            changes_seen    = '0;
            averages_seeded = 1'b0;
            gain_avg        = '0;
            loss_avg        = '0;
            rsi_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (rsi_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected result rsi %0d loss_zero %0b", $realtime,
                                 i_rsi_hundredths, i_loss_was_zero);
                    end
                    mismatches++;
                end else begin
                    want = rsi_due.pop_front();
                    if (want.rsi !== i_rsi_hundredths || want.loss_zero !== i_loss_was_zero)
                    begin
                        if (mismatches < 10) begin
                            $display("%0t: rsi expected %0d got %0d, loss_zero expected %0b got %0b",
                                     $realtime, want.rsi, i_rsi_hundredths, want.loss_zero,
                                     i_loss_was_zero);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                smoothing_len = i_cfg_wr_data;
            end
            if (i_in_valid && !i_in_stall) begin
                advance_series(i_close_price, i_restart);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= rsi_due.size();
    end

endmodule

// ===== dv/wilder_rsi_stream_tb.sv =====
`timescale 1ns / 1ps

module wilder_rsi_stream_tb;

    localparam int IDLE_MAX      = 17;
    localparam int SETTLE_CYCLES = 160;
    localparam int HOLD_CYCLES   = 3000;
    localparam int HOLD_AT       = 30;
    localparam int WATCHDOG      = 20000;

    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              in_valid      = 1'b0;
    logic                              in_stall;
    logic [31:0]                       close_price   = '0;
    logic                              restart       = 1'b0;
    logic                              out_valid;
    logic                              out_stall     = 1'b0;
    logic [wrsi_pkg::RSI_W-1:0]        rsi_hundredths;
    logic                              loss_was_zero;
    logic                              cfg_wr_en     = 1'b0;
    logic [wrsi_pkg::PERIOD_W-1:0]     cfg_wr_data   = '0;

    int                                fail_count;
    int                                pending;
    int                                quiet_cycles  = 0;
    logic [31:0]                       last_sent     = '0;

    always #5 clk = ~clk;

    wilder_rsi_stream dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_close_price    (close_price),
        .i_restart        (restart),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_rsi_hundredths (rsi_hundredths),
        .o_loss_was_zero  (loss_was_zero),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data)
    );

    wilder_rsi_stream_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_close_price    (close_price),
        .i_restart        (restart),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_rsi_hundredths (rsi_hundredths),
        .i_loss_was_zero  (loss_was_zero),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // The receiver holds off at random and once for a long stretch so that the block fills up.
    initial begin
        int gap;
        int taken;

        taken = 0;
        forever begin
            if (taken == HOLD_AT) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                gap = ((taken / 25) % 4 == 3) ? 0 : $urandom_range(0, IDLE_MAX);
                if (gap > 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    function automatic logic [31:0] next_close(input logic [31:0] prev);
        int mode;

        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            return prev + 32'($urandom_range(0, 2000)) - 32'd1000;
        end
        if (mode == 6) begin
            return prev;
        end
        if (mode == 9) begin
            return prev ^ (32'd1 << $urandom_range(0, 31));
        end
        return $urandom;
    endfunction

    task automatic send_close(input logic [31:0] price, input logic fresh, input int idle_cap);
        int gap;

        gap = $urandom_range(0, idle_cap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        close_price <= price;
        restart     <= fresh;
        do @(posedge clk); while (in_stall);
        last_sent = price;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_period(input logic [wrsi_pkg::PERIOD_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input logic [wrsi_pkg::PERIOD_W-1:0] period, input int items,
                             input logic fresh_start, input int idle_cap);
        logic fresh;
        int   k;

        set_period(period);
        for (k = 0; k < items; k++) begin
            if (k == 0) begin
                fresh = fresh_start;
            end else begin
                fresh = (period < 100) && ($urandom_range(0, 39) == 0);
            end
            send_close(next_close(last_sent), fresh, idle_cap);
        end
        settle();
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // A period of one makes every change produce an item.
        set_period(8'd1);
        send_close(32'd7, 1'b0, IDLE_MAX);
        send_close(32'hFFFF_FFFF, 1'b0, IDLE_MAX);
        send_close(32'h0000_0000, 1'b0, IDLE_MAX);
        send_close(32'h0000_0000, 1'b0, IDLE_MAX);
        send_close(32'h0000_0000, 1'b1, IDLE_MAX);
        send_close(32'hFFFF_FFFF, 1'b1, IDLE_MAX);
        send_close(32'hFFFF_FFFE, 1'b0, IDLE_MAX);
        send_close(32'h8000_0000, 1'b0, IDLE_MAX);
        send_close(32'h7FFF_FFFF, 1'b0, IDLE_MAX);
        send_close(32'h5555_5555, 1'b0, IDLE_MAX);
        send_close(32'hAAAA_AAAA, 1'b0, IDLE_MAX);
        settle();

        set_period(8'd2);
        send_close(32'd100, 1'b1, IDLE_MAX);
        send_close(32'd103, 1'b0, IDLE_MAX);
        send_close(32'd101, 1'b0, IDLE_MAX);
        send_close(32'd101, 1'b0, IDLE_MAX);
        send_close(32'd0, 1'b0, IDLE_MAX);
        send_close(32'hFFFF_FFFF, 1'b0, IDLE_MAX);
        settle();

        // A period of zero behaves as a period of one.
        set_period(8'd0);
        send_close(32'd5, 1'b0, IDLE_MAX);
        send_close(32'd9, 1'b0, IDLE_MAX);
        send_close(32'd2, 1'b0, IDLE_MAX);
        send_close(32'd2, 1'b1, IDLE_MAX);
        send_close(32'd3, 1'b0, IDLE_MAX);
        settle();
        last_sent = $urandom;

        run_phase(8'd14, 70, 1'b1, IDLE_MAX);
        run_phase(8'd3, 50, 1'b0, 0);
        run_phase(8'd255, 300, 1'b1, IDLE_MAX);
        // The next phase leaves the count mid warm-up, and the one after seeds with a
        // shorter period than the count already reached.
        run_phase(8'd20, 10, 1'b1, IDLE_MAX);
        run_phase(8'd5, 40, 1'b0, 0);
        run_phase(8'(($urandom_range(1, 16))), 60, 1'($urandom_range(0, 1)), IDLE_MAX);
        run_phase(8'd1, 50, 1'b0, IDLE_MAX);
        run_phase(8'd2, 50, 1'b1, 0);
        run_phase(8'(($urandom_range(1, 16))), 60, 1'($urandom_range(0, 1)), IDLE_MAX);
        run_phase(8'(($urandom_range(1, 16))), 60, 1'($urandom_range(0, 1)), IDLE_MAX);
        run_phase(8'd128, 140, 1'b1, 0);
        run_phase(8'd14, 60, 1'b0, IDLE_MAX);

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
